>>> rtl/ihd_pkg.sv
// Shared types and constants for the impact hysteresis detector.
// Used by ihd_cfg, ihd_core and impact_hysteresis_detector; depends on nothing.
`timescale 1ns / 1ps

package ihd_pkg;

  localparam int unsigned LevelW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_TRIGGER_LEVEL     = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_LEVEL     = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_RETRIGGER_LOCKOUT = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_DEBOUNCE  = 8'd3;

  // Reset values of the registers
  localparam logic [LevelW-1:0] TRIGGER_LEVEL_RST     = 16'd2000;
  localparam logic [LevelW-1:0] RELEASE_LEVEL_RST     = 16'd500;
  localparam logic [TimeW-1:0]  RETRIGGER_LOCKOUT_RST = 32'd100000;
  localparam logic [TimeW-1:0]  RELEASE_DEBOUNCE_RST  = 32'd20000;

  typedef struct packed {
    logic [LevelW-1:0] trigger_level;
    logic [LevelW-1:0] release_level;
    logic [TimeW-1:0]  retrigger_lockout;
    logic [TimeW-1:0]  release_debounce;
  } cfg_t;

  // Detector state flags, exported for checking
  typedef struct packed {
    logic impact_active;
    logic release_waiting;
    logic ever_triggered;
  } stat_t;

  // One decoded sample
  typedef struct packed {
    logic [TimeW-1:0]  sample_time;
    logic [LevelW-1:0] force_sample;
    logic              sample_valid;
  } sample_t;

  typedef struct packed {
    logic release_pulse;
    logic trigger_pulse;
  } pulse_t;

endpackage

>>> rtl/ihd_cfg.sv
// Configuration register file of the impact hysteresis detector.
// Depends on ihd_pkg.
`timescale 1ns / 1ps

module ihd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [ihd_pkg::CfgIdxW-1:0]   wr_idx,
  input  logic [ihd_pkg::CfgDatW-1:0]   wr_data,
  output ihd_pkg::cfg_t                 cfg
);

  ihd_pkg::cfg_t cfg_r;
  ihd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        ihd_pkg::REG_TRIGGER_LEVEL:
          cfg_nxt.trigger_level = wr_data[ihd_pkg::LevelW-1:0];
        ihd_pkg::REG_RELEASE_LEVEL:
          cfg_nxt.release_level = wr_data[ihd_pkg::LevelW-1:0];
        ihd_pkg::REG_RETRIGGER_LOCKOUT:
          cfg_nxt.retrigger_lockout = wr_data[ihd_pkg::TimeW-1:0];
        ihd_pkg::REG_RELEASE_DEBOUNCE:
          cfg_nxt.release_debounce = wr_data[ihd_pkg::TimeW-1:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_level     <= ihd_pkg::TRIGGER_LEVEL_RST;
      cfg_r.release_level     <= ihd_pkg::RELEASE_LEVEL_RST;
      cfg_r.retrigger_lockout <= ihd_pkg::RETRIGGER_LOCKOUT_RST;
      cfg_r.release_debounce  <= ihd_pkg::RELEASE_DEBOUNCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/ihd_core.sv
// Decision logic and state of the impact hysteresis detector.
// Depends on ihd_pkg.
`timescale 1ns / 1ps

module ihd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  ihd_pkg::sample_t smp,
  input  ihd_pkg::cfg_t    cfg,
  output ihd_pkg::pulse_t  pulse,
  output ihd_pkg::stat_t   stat
);

  ihd_pkg::stat_t              stat_r;
  ihd_pkg::stat_t              stat_nxt;
  logic [ihd_pkg::TimeW-1:0]   last_trig_r;
  logic [ihd_pkg::TimeW-1:0]   last_trig_nxt;
  logic [ihd_pkg::TimeW-1:0]   rel_start_r;
  logic [ihd_pkg::TimeW-1:0]   rel_start_nxt;
  logic [ihd_pkg::TimeW-1:0]   lock_span;
  logic [ihd_pkg::TimeW-1:0]   deb_span;
  logic                        lock_done;
  logic                        deb_done;

  // Elapsed times wrap modulo 2^32
  assign lock_span = smp.sample_time - last_trig_r;
  assign deb_span  = smp.sample_time - rel_start_r;
  assign lock_done = lock_span >= cfg.retrigger_lockout;
  assign deb_done  = deb_span >= cfg.release_debounce;

  always_comb begin
    stat_nxt      = stat_r;
    last_trig_nxt = last_trig_r;
    rel_start_nxt = rel_start_r;
    pulse         = '0;
    if (step) begin
      if (!smp.sample_valid) begin
        stat_nxt.release_waiting = 1'b0;
      end else if (!stat_r.impact_active) begin
        if (smp.force_sample >= cfg.trigger_level &&
            (!stat_r.ever_triggered || lock_done)) begin
          stat_nxt.impact_active   = 1'b1;
          stat_nxt.release_waiting = 1'b0;
          stat_nxt.ever_triggered  = 1'b1;
          last_trig_nxt            = smp.sample_time;
          pulse.trigger_pulse      = 1'b1;
        end
      end else if (smp.force_sample > cfg.release_level) begin
        stat_nxt.release_waiting = 1'b0;
      end else if (!stat_r.release_waiting) begin
        // first low sample only opens the debounce window
        stat_nxt.release_waiting = 1'b1;
        rel_start_nxt            = smp.sample_time;
      end else if (deb_done) begin
        stat_nxt.impact_active   = 1'b0;
        stat_nxt.release_waiting = 1'b0;
        pulse.release_pulse      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r      <= '0;
      last_trig_r <= '0;
      rel_start_r <= '0;
    end else begin
      stat_r      <= stat_nxt;
      last_trig_r <= last_trig_nxt;
      rel_start_r <= rel_start_nxt;
    end
  end

  assign stat = stat_r;

endmodule

>>> rtl/impact_hysteresis_detector.sv
// Top level of the impact hysteresis detector: input and result registers.
// Depends on ihd_pkg, ihd_cfg and ihd_core.
`timescale 1ns / 1ps

// Force threshold detector with hysteresis, release debounce and retrigger
// lockout. Each input beat on in_* carries one timestamped force sample and
// produces exactly one result beat on out_* with trigger and release pulses.
//
// Channels: in_* and out_* are stream channels (tvalid/tready). cfg_* writes
// one of four registers (index 0..3); other indexes are dropped. cfg_ready
// is always high. Write configuration only while no sample is in flight.
//
// Path: the input register holds an accepted beat, then the decision logic
// loads the result register. Throughput: one sample per cycle while the
// result register is free or draining, set by the combinational compare and
// subtract path that updates the detector state from the input register.
//
// Reset (rst_n low, synchronous): registers return to their defaults, the
// detector goes idle with no trigger history, and both stages empty.
//
// Stall: when out_tready is low with a result held, the input register holds
// its sample and in_tready drops once it is full; nothing is lost.

module impact_hysteresis_detector (
  input  logic                        clk,
  input  logic                        rst_n,
  // tdata: sample_time[31:0], force_sample[47:32]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [47:0]                 in_tdata,
  // tuser: sample_valid[0]
  input  logic [0:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // tdata: trigger_pulse[0], release_pulse[1], zero fill [7:2]
  output logic [7:0]                  out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ihd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ihd_pkg::CfgDatW-1:0] cfg_data
);

  ihd_pkg::cfg_t    cfg;
  ihd_pkg::sample_t smp_r;
  ihd_pkg::pulse_t  pulse;
  ihd_pkg::pulse_t  res_r;
  ihd_pkg::stat_t   stat;
  logic             in_vld_r;
  logic             in_vld_nxt;
  logic             out_vld_r;
  logic             out_vld_nxt;
  logic             advance;
  logic             step;
  logic             in_fire;

  assign cfg_ready = 1'b1;

  ihd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // Advance the pipe whenever the result register is free or being drained
  assign advance   = !out_vld_r || out_tready;
  assign step      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign in_vld_nxt  = in_fire ? 1'b1 : (step ? 1'b0 : in_vld_r);
  assign out_vld_nxt = step ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  ihd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .smp   (smp_r),
    .cfg   (cfg),
    .pulse (pulse),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: the sample loads on accept, the result on each step; both hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_r.sample_time  <= in_tdata[ihd_pkg::TimeW-1:0];
      smp_r.force_sample <= in_tdata[ihd_pkg::TimeW +: ihd_pkg::LevelW];
      smp_r.sample_valid <= in_tuser[0];
    end
    if (step) begin
      res_r <= pulse;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, res_r.release_pulse, res_r.trigger_pulse};

  // A sample can never both start and end an impact
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.trigger_pulse && res_r.release_pulse))
    else $error("trigger and release in the same result");

  // A trigger only fires from idle and leaves the detector active
  a_trig_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && pulse.trigger_pulse |-> !stat.impact_active ##1 stat.impact_active)
    else $error("trigger fired while active or did not activate");

  // A release only fires from a running debounce and leaves the detector idle
  a_rel_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step && pulse.release_pulse |-> stat.release_waiting ##1 !stat.impact_active)
    else $error("release without debounce or detector still active");

  // A stalled result holds the sample in place rather than dropping it
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready && in_vld_r |=> in_vld_r && out_vld_r)
    else $error("stage lost a beat during a stall");

endmodule

>>> tb/sv/impact_hysteresis_detector_tb.sv
// Self-checking testbench for impact_hysteresis_detector: directed and random force samples.
// Depends on ihd_pkg and the detector RTL; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module impact_hysteresis_detector_tb;
  import ihd_pkg::*;

  localparam int IdlePct     = 22;    // chance per cycle that a side idles
  localparam int ResetCycles = 3;
  localparam int Phases      = 5;
  localparam int PhaseItems  = 250;   // random samples per configuration phase
  localparam int QuietFirst  = 500;   // random-sample window with no idling on either side
  localparam int QuietLast   = 700;
  localparam int DrainCycles = 10;    // settle time after the last result beat
  localparam int StallLimit  = 2000;  // cycles without any beat before the run is abandoned

  // First index past the register file; writes here must be dropped
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = REG_RELEASE_DEBOUNCE + 1'b1;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {SEG_HIGH, SEG_LOW, SEG_NOISE} seg_kind_t;

  // One entry of the directed table: a sample beat, optionally with a hand-typed
  // result, or a register write issued once the detector has drained.
  typedef struct {
    row_kind_t           kind;
    sample_t             s;
    bit                  typed;
    pulse_t              want;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDatW-1:0]  data;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [47:0]         in_tdata = '0;    // sample_time[31:0], force_sample[47:32]
  logic [0:0]          in_tuser = '0;    // sample_valid[0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;        // trigger_pulse[0], release_pulse[1], zero fill
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDatW-1:0]  cfg_data = '0;

  impact_hysteresis_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow registers and detector state, advanced once per accepted
  // sample beat.
  // ---------------------------------------------------------------------------
  logic [LevelW-1:0] lvl_trig      = TRIGGER_LEVEL_RST;
  logic [LevelW-1:0] lvl_rel       = RELEASE_LEVEL_RST;
  logic [TimeW-1:0]  span_lockout  = RETRIGGER_LOCKOUT_RST;
  logic [TimeW-1:0]  span_debounce = RELEASE_DEBOUNCE_RST;

  logic             det_active    = 1'b0;
  logic             det_waiting   = 1'b0;  // a low-force run is being timed
  logic             det_fired     = 1'b0;  // lockout only counts once a trigger happened
  logic [TimeW-1:0] det_last_trig = '0;
  logic [TimeW-1:0] det_low_start = '0;

  pulse_t      pending_pulses[$];  // expected result beats, oldest first
  int unsigned mismatches = 0;
  bit          quiet = 1'b0;       // suppress idling on both sides
  int unsigned stall_cycles = 0;

  function automatic pulse_t detect_step(input sample_t s);
    pulse_t           p;
    logic [TimeW-1:0] since_trig;
    logic [TimeW-1:0] since_low;
    p = '0;
    // Differences wrap modulo 2^32 so a timestamp rollover is harmless
    since_trig = s.sample_time - det_last_trig;
    since_low  = s.sample_time - det_low_start;
    if (!s.sample_valid) begin
      // A gap breaks any low-force run but leaves the impact state alone
      det_waiting = 1'b0;
    end else if (!det_active) begin
      if (s.force_sample >= lvl_trig && (!det_fired || since_trig >= span_lockout)) begin
        det_active    = 1'b1;
        det_waiting   = 1'b0;
        det_fired     = 1'b1;
        det_last_trig = s.sample_time;
        p.trigger_pulse = 1'b1;
      end
    end else if (s.force_sample > lvl_rel) begin
      det_waiting = 1'b0;
    end else if (!det_waiting) begin
      // The first low sample only opens the debounce window
      det_waiting   = 1'b1;
      det_low_start = s.sample_time;
    end else if (since_low >= span_debounce) begin
      det_active  = 1'b0;
      det_waiting = 1'b0;
      p.release_pulse = 1'b1;
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic step_row_t row_checked(input logic [TimeW-1:0] t,
                                            input logic [LevelW-1:0] f, input logic v,
                                            input logic trig, input logic rel);
    step_row_t r;
    r.kind = ROW_SAMPLE;
    r.s.sample_time  = t;
    r.s.force_sample = f;
    r.s.sample_valid = v;
    r.typed = 1'b1;
    r.want.trigger_pulse = trig;
    r.want.release_pulse = rel;
    r.idx  = '0;
    r.data = '0;
    return r;
  endfunction

  function automatic step_row_t row_sample(input logic [TimeW-1:0] t,
                                           input logic [LevelW-1:0] f, input logic v);
    step_row_t r;
    r = row_checked(t, f, v, 1'b0, 1'b0);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic step_row_t row_write(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDatW-1:0] data);
    step_row_t r;
    r = row_sample('0, '0, 1'b0);
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one sample beat after a random idle run, hold it until accepted,
  // then queue its expected result. Leave tvalid high on return.
  task automatic send_sample(input sample_t s, input bit typed, input pulse_t want);
    pulse_t got;
    while (!quiet && $urandom_range(0, 99) < IdlePct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.force_sample, s.sample_time};
    in_tuser  <= s.sample_valid;
    do @(posedge clk); while (!in_tready);
    got = detect_step(s);
    pending_pulses.push_back(typed ? want : got);
  endtask

  // Write one register once every outstanding result has come back. The caller
  // must have dropped in_tvalid already. Return in the cycle after the beat so that
  // back-to-back writes never touch cfg_valid twice in one step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    while (pending_pulses.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TRIGGER_LEVEL:     lvl_trig      = data[LevelW-1:0];
      REG_RELEASE_LEVEL:     lvl_rel       = data[LevelW-1:0];
      REG_RETRIGGER_LOCKOUT: span_lockout  = data[TimeW-1:0];
      REG_RELEASE_DEBOUNCE:  span_debounce = data[TimeW-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and field-by-field compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pulse_t want;
    out_tready <= quiet || ($urandom_range(0, 99) >= IdlePct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pulses.size() == 0) begin
        $error("result beat with no sample waiting: out_tdata %02h", out_tdata);
        mismatches++;
      end else begin
        want = pending_pulses.pop_front();
        if (out_tdata[0] !== want.trigger_pulse) begin
          $error("trigger_pulse: expected %0b, got %0b", want.trigger_pulse, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[1] !== want.release_pulse) begin
          $error("release_pulse: expected %0b, got %0b", want.release_pulse, out_tdata[1]);
          mismatches++;
        end
      end
    end
  end

  // Abandon the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    step_row_t         plan[$];
    sample_t           s;
    logic [TimeW-1:0]  t;
    logic [LevelW-1:0] trig_cfg;
    logic [LevelW-1:0] rel_cfg;
    logic [TimeW-1:0]  lockout_cfg;
    logic [TimeW-1:0]  debounce_cfg;
    int unsigned       dt_max;
    bit                backward;
    seg_kind_t         seg;
    int unsigned       seg_left;
    int unsigned       pick;
    int unsigned       n;

    // Directed table, starting from the reset register values.
    plan.push_back(row_checked(32'd0, 16'd0, 1'b1, 1'b0, 1'b0));       // below trigger
    plan.push_back(row_checked(32'd10, 16'hFFFF, 1'b0, 1'b0, 1'b0));   // gap, full-scale force
    plan.push_back(row_checked(32'd20, 16'd2000, 1'b1, 1'b1, 1'b0));   // first trigger, no lockout
    plan.push_back(row_checked(32'd40, 16'd500, 1'b1, 1'b0, 1'b0));    // opens debounce
    plan.push_back(row_sample(32'd20039, 16'd0, 1'b1));                // one us short
    plan.push_back(row_checked(32'd20040, 16'd100, 1'b1, 1'b0, 1'b1)); // release on the boundary
    plan.push_back(row_checked(32'd50000, 16'd3000, 1'b1, 1'b0, 1'b0)); // held off by lockout
    plan.push_back(row_checked(32'd100020, 16'd2000, 1'b1, 1'b1, 1'b0)); // lockout just ended
    plan.push_back(row_sample(32'd100100, 16'd400, 1'b1));
    plan.push_back(row_sample(32'd110000, 16'd600, 1'b1));             // rise restarts debounce
    plan.push_back(row_sample(32'd110100, 16'd300, 1'b1));
    plan.push_back(row_checked(32'd120000, 16'd300, 1'b0, 1'b0, 1'b0)); // gap restarts debounce
    plan.push_back(row_sample(32'd140000, 16'd300, 1'b1));
    plan.push_back(row_checked(32'd160000, 16'd500, 1'b1, 1'b0, 1'b1));
    // Zero spans; trigger level written with junk in the upper half
    plan.push_back(row_write(REG_RELEASE_DEBOUNCE, 32'd0));
    plan.push_back(row_write(REG_RETRIGGER_LOCKOUT, 32'd0));
    plan.push_back(row_write(REG_TRIGGER_LEVEL, 32'hABCD_0064));
    plan.push_back(row_write(REG_UNMAPPED, 32'd5));
    plan.push_back(row_checked(32'hFFFF_FFF0, 16'd99, 1'b1, 1'b0, 1'b0));
    plan.push_back(row_checked(32'hFFFF_FFF0, 16'd100, 1'b1, 1'b1, 1'b0));
    plan.push_back(row_checked(32'd5, 16'd0, 1'b1, 1'b0, 1'b0));       // first low never releases
    plan.push_back(row_checked(32'd5, 16'd0, 1'b1, 1'b0, 1'b1));       // zero debounce releases
    plan.push_back(row_checked(32'd6, 16'hFFFF, 1'b1, 1'b1, 1'b0));    // zero lockout retriggers
    // Full-scale spans and levels; differences must wrap
    plan.push_back(row_write(REG_RETRIGGER_LOCKOUT, 32'hFFFF_FFFF));
    plan.push_back(row_write(REG_RELEASE_DEBOUNCE, 32'hFFFF_FFFF));
    plan.push_back(row_write(REG_RELEASE_LEVEL, 32'h0000_FFFF));
    plan.push_back(row_write(REG_TRIGGER_LEVEL, 32'h0000_FFFF));
    plan.push_back(row_sample(32'd100, 16'hFFFF, 1'b1));
    plan.push_back(row_checked(32'd99, 16'd0, 1'b1, 1'b0, 1'b1));
    plan.push_back(row_checked(32'd200, 16'hFFFF, 1'b1, 1'b0, 1'b0));
    plan.push_back(row_checked(32'd5, 16'hFFFF, 1'b1, 1'b1, 1'b0));
    plan.push_back(row_write(REG_RELEASE_LEVEL, 32'd0));
    plan.push_back(row_checked(32'd6, 16'd1, 1'b1, 1'b0, 1'b0));
    plan.push_back(row_sample(32'd7, 16'd0, 1'b1));

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        in_tvalid <= 1'b0;
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].s, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting.
    n = 0;
    for (int ph = 0; ph < Phases; ph++) begin
      trig_cfg = 16'($urandom_range(1000, 65535));
      rel_cfg  = 16'($urandom_range(0, trig_cfg));
      backward = 1'b0;
      case (ph)
        0: begin
          // Defaults, with realistic sample spacing
          trig_cfg = TRIGGER_LEVEL_RST;
          rel_cfg  = RELEASE_LEVEL_RST;
          lockout_cfg  = RETRIGGER_LOCKOUT_RST;
          debounce_cfg = RELEASE_DEBOUNCE_RST;
          dt_max = 8000;
        end
        1: begin
          lockout_cfg  = '0;
          debounce_cfg = '0;
          dt_max = 100;
        end
        2: begin
          lockout_cfg  = $urandom_range(1, 3000);
          debounce_cfg = $urandom_range(1, 800);
          dt_max = 300;
        end
        3: begin
          // Near full-scale spans: only a clock running backwards reaches them
          lockout_cfg  = 32'hFFFF_FFFF - $urandom_range(0, 3000);
          debounce_cfg = 32'hFFFF_FFFF - $urandom_range(0, 800);
          dt_max = 300;
          backward = 1'b1;
        end
        default: begin
          trig_cfg = 16'hFFFF;
          rel_cfg  = 16'h0000;
          lockout_cfg  = $urandom_range(0, 50000);
          debounce_cfg = $urandom_range(0, 5000);
          dt_max = 3000;
        end
      endcase

      in_tvalid <= 1'b0;
      write_reg(REG_TRIGGER_LEVEL, {16'($urandom), trig_cfg});
      write_reg(REG_RELEASE_LEVEL, {16'($urandom), rel_cfg});
      write_reg(REG_RETRIGGER_LOCKOUT, lockout_cfg);
      write_reg(REG_RELEASE_DEBOUNCE, debounce_cfg);
      write_reg(CfgIdxW'($urandom_range(REG_UNMAPPED, {CfgIdxW{1'b1}})), $urandom);

      t = $urandom;
      seg_left = 0;
      seg = SEG_NOISE;
      for (int k = 0; k < PhaseItems; k++) begin
        quiet = (n >= QuietFirst && n < QuietLast);
        n++;
        // Mostly runs of samples at or above trigger and of samples at or below
        // release, in random order; the rest is noise across the whole field range.
        if (seg_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            seg = SEG_HIGH;
            seg_left = $urandom_range(1, 4);
          end else if (pick < 85) begin
            seg = SEG_LOW;
            seg_left = $urandom_range(1, 10);
          end else begin
            seg = SEG_NOISE;
            seg_left = $urandom_range(1, 4);
          end
        end
        seg_left--;
        if ($urandom_range(0, 99) < 2) begin
          t = $urandom;
        end else if (backward) begin
          t = t - $urandom_range(0, dt_max);
        end else begin
          t = t + $urandom_range(0, dt_max);
        end
        s.sample_time = t;
        case (seg)
          SEG_HIGH: begin
            s.force_sample = 16'($urandom_range(lvl_trig, 16'hFFFF));
            s.sample_valid = ($urandom_range(0, 99) >= 5);
          end
          SEG_LOW: begin
            s.force_sample = 16'($urandom_range(0, lvl_rel));
            s.sample_valid = ($urandom_range(0, 99) >= 5);
          end
          default: begin
            s.force_sample = 16'($urandom);
            s.sample_valid = 1'($urandom);
          end
        endcase
        send_sample(s, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    // Drop the input, wait out every result, then give stragglers time to show.
    in_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ihd_pkg.sv
rtl/ihd_cfg.sv
rtl/ihd_core.sv
rtl/impact_hysteresis_detector.sv
tb/sv/impact_hysteresis_detector_tb.sv
